// ===== rtl/block_rms_meter_defines.svh =====
// Assertion macros used by the RMS meter top level.
`ifndef BLOCK_RMS_METER_DEFINES_SVH
`define BLOCK_RMS_METER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked at every clock edge outside reset.
`define RMS_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define RMS_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`else

`define RMS_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define RMS_ASSERT_ALWAYS(lbl, clk_s, prop, msg)

`endif

`endif

// ===== rtl/rms_pkg.sv =====
// Shared widths, defaults and types of the RMS meter.
package rms_pkg;

  localparam int SAMPLE_W   = 16;  // signed input sample
  localparam int RMS_W      = 16;  // unsigned RMS result
  localparam int MAG_W      = 17;  // magnitude of a sample, up to 32768
  localparam int SQ_W       = 31;  // square of a magnitude, up to 2^30
  localparam int RAD_W      = 32;  // radicand of the square root
  localparam int ROOT_W     = 16;  // root, one bit per step
  localparam int SQ_REM_W   = 18;  // partial remainder of the square root
  localparam int WINDOW_DEF = 64;

  // Status of the divide/root sequencer as seen by the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } core_status_t;

endpackage

// ===== rtl/rms_in_if.sv =====
// Input channel of the RMS meter: one signed sample per item.
interface rms_in_if;
  import rms_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/rms_out_if.sv =====
// Output channel of the RMS meter: held RMS and window flag per item.
interface rms_out_if;
  import rms_pkg::*;

  logic             valid;
  logic             ready;
  logic [RMS_W-1:0] rms;
  logic             window_done;

  modport source (output valid, output rms, output window_done, input ready);
  modport sink (input valid, input rms, input window_done, output ready);
endinterface

// ===== rtl/rms_csub.sv =====
// Shared compare-and-subtract unit used by the divide and root steps.
module rms_csub #(
  parameter int W = 18
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);
  logic [W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[W-1:0];
  // No borrow out means a >= b.
  assign ge   = ~full[W];
endmodule

// ===== rtl/rms_core.sv =====
// Sequencer that divides the window sum and takes its integer square root.
module rms_core #(
  parameter int WINDOW = rms_pkg::WINDOW_DEF,
  parameter int SUM_W  = rms_pkg::SQ_W + $clog2(rms_pkg::WINDOW_DEF)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [SUM_W-1:0]           sum,
  output rms_pkg::core_status_t      status,
  output logic [rms_pkg::ROOT_W-1:0] root
);
  import rms_pkg::*;

  localparam bit POW2   = (WINDOW & (WINDOW - 1)) == 0;
  localparam int LOG2W  = $clog2(WINDOW);
  localparam int DREM_W = $clog2(WINDOW) + 2;
  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int ALU_W  = (DREM_W > SQ_REM_W) ? DREM_W : SQ_REM_W;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_DIV  = 2'd1;
  localparam logic [1:0] C_SQRT = 2'd2;

  logic [1:0]          state;
  logic [STEP_W-1:0]   steps;
  logic                done;
  logic [SUM_W-1:0]    dq;
  logic [DREM_W-1:0]   drem;
  logic [RAD_W-1:0]    rad;
  logic [SQ_REM_W-1:0] srem;

  logic [DREM_W-1:0]   div_trial;
  logic [SQ_REM_W-1:0] sq_trial;
  logic [ALU_W-1:0]    alu_a;
  logic [ALU_W-1:0]    alu_b;
  logic [ALU_W-1:0]    alu_diff;
  logic                alu_ge;
  logic [SUM_W-1:0]    dq_shift;

  // Restoring division brings down one dividend bit per step; the root
  // brings down two radicand bits per step and tries 4*root + 1.
  assign div_trial = {drem[DREM_W-2:0], dq[SUM_W-1]};
  assign sq_trial  = {srem[SQ_REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign dq_shift  = {dq[SUM_W-2:0], alu_ge};

  always_comb begin
    if (state == C_DIV) begin
      alu_a = ALU_W'(div_trial);
      alu_b = ALU_W'(WINDOW);
    end else begin
      alu_a = ALU_W'(sq_trial);
      alu_b = ALU_W'({root, 2'b01});
    end
  end

  rms_csub #(.W(ALU_W)) u_csub (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            srem <= '0;
            root <= '0;
            drem <= '0;
            if (POW2) begin
              rad   <= RAD_W'(sum >> LOG2W);
              steps <= STEP_W'(ROOT_W);
              state <= C_SQRT;
            end else begin
              dq    <= sum;
              steps <= STEP_W'(SUM_W);
              state <= C_DIV;
            end
          end
        end
        C_DIV: begin
          drem  <= alu_ge ? DREM_W'(alu_diff) : div_trial;
          dq    <= dq_shift;
          steps <= steps - 1'b1;
          if (steps == STEP_W'(1)) begin
            rad   <= RAD_W'(dq_shift);
            steps <= STEP_W'(ROOT_W);
            state <= C_SQRT;
          end
        end
        C_SQRT: begin
          srem  <= alu_ge ? SQ_REM_W'(alu_diff) : sq_trial;
          root  <= {root[ROOT_W-2:0], alu_ge};
          rad   <= rad << 2;
          steps <= steps - 1'b1;
          if (steps == STEP_W'(1)) begin
            done  <= 1'b1;
            state <= C_IDLE;
          end
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

  assign status.busy = (state != C_IDLE);
  assign status.done = done;
endmodule

// ===== rtl/block_rms_meter.sv =====
// Top level of the windowed RMS meter.
//
// Usage: each item on the samples channel carries one signed 16-bit sample.
// Every accepted item yields exactly one item on the results channel: the
// RMS of the most recently completed window and window_done, which is set on
// the item that closed a window. A window is WINDOW samples; its RMS is
// floor(sqrt(floor(sum of squares / WINDOW))), and rms reads 0 until the
// first window closes.
// Flow: an accepted item's magnitude is registered, squared in S_SQ, added
// in S_ADD and written to the output register from S_PUSH once it is free.
// An item that closes a window also runs the shared compare-subtract unit
// in S_ROOT: 16 root steps when WINDOW is a power of two, plus one divide
// step per sum bit (31 + clog2(WINDOW)) otherwise. The block takes one
// item at a time; ready is high only while no item is in work, and the next
// item may enter as soon as the previous result sits in the output register.
// Reset (rst, synchronous) clears the sum, the sample count, the held RMS
// and the output valid. When the receiver stalls, the result waits in the
// output register, one more item may be worked on, and its result then
// waits until the register is taken.
module block_rms_meter #(
  parameter int WINDOW = rms_pkg::WINDOW_DEF
) (
  input logic      clk,
  input logic      rst,
  rms_in_if.sink   samples,
  rms_out_if.source results
);
  import rms_pkg::*;
  `include "block_rms_meter_defines.svh"

  localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  // A full window of most negative samples sums to WINDOW * 2^30.
  localparam int SUM_W = SQ_W + $clog2(WINDOW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  logic [2:0]         state;
  logic [CNT_W-1:0]   count;
  logic [SUM_W-1:0]   sum;
  logic [RMS_W-1:0]   held_rms;
  logic [MAG_W-1:0]   mag;
  logic [SQ_W-1:0]    sq;
  logic               res_done;
  logic               out_valid;
  logic [RMS_W-1:0]   out_rms;
  logic               out_done;

  logic [MAG_W-1:0]   samp_ext;
  logic [MAG_W-1:0]   mag_c;
  logic [2*MAG_W-1:0] prod;
  logic [SUM_W-1:0]   sum_total;
  logic               last;
  logic               core_start;
  core_status_t       core_st;
  logic [ROOT_W-1:0]  core_root;

  // Magnitude of the sample in 17 bits, so -32768 becomes 32768.
  assign samp_ext  = {samples.sample[SAMPLE_W-1], samples.sample};
  assign mag_c     = samp_ext[MAG_W-1] ? (~samp_ext + 1'b1) : samp_ext;
  assign prod      = mag * mag;
  assign sum_total = sum + SUM_W'(sq);
  assign last      = (count == CNT_W'(WINDOW - 1));

  // The closing sum goes straight into the divide/root sequencer.
  assign core_start = (state == S_ADD) && last;

  rms_core #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (core_start),
    .sum    (sum_total),
    .status (core_st),
    .root   (core_root)
  );

  assign samples.ready       = (state == S_IDLE);
  assign results.valid       = out_valid;
  assign results.rms         = out_rms;
  assign results.window_done = out_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sum       <= '0;
      held_rms  <= '0;
      out_valid <= 1'b0;
    end else begin
      // The output register empties when taken. In S_PUSH the refill below
      // decides its valid instead.
      if (results.ready && (state != S_PUSH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (samples.valid) begin
            mag   <= mag_c;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sq    <= prod[SQ_W-1:0];
          state <= S_ADD;
        end
        S_ADD: begin
          if (last) begin
            sum   <= '0;
            count <= '0;
            state <= S_ROOT;
          end else begin
            sum      <= sum_total;
            count    <= count + 1'b1;
            res_done <= 1'b0;
            state    <= S_PUSH;
          end
        end
        S_ROOT: begin
          if (core_st.done) begin
            held_rms <= core_root;
            res_done <= 1'b1;
            state    <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!out_valid || results.ready) begin
            out_rms   <= held_rms;
            out_done  <= res_done;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The sequencer never runs while a new item can enter.
  `RMS_ASSERT(a_ready_not_busy, clk, rst, samples.ready |-> !core_st.busy, "ready while root busy")
  // A root result only arrives while the top level waits for it.
  `RMS_ASSERT(a_done_in_root, clk, rst, core_st.done |-> state == S_ROOT, "root done out of place")
  // The sample count stays inside the window.
  `RMS_ASSERT(a_count_range, clk, rst, count <= CNT_W'(WINDOW - 1), "sample count overflow")
  // An accepted item always moves on to squaring.
  `RMS_ASSERT(a_accept_sq, clk, rst, samples.valid && samples.ready |=> state == S_SQ, "accept lost")
  // Reset leaves the block idle with no result pending.
  `RMS_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> state == S_IDLE && !results.valid, "reset state")
endmodule

// ===== test/rms_meter_checker.sv =====
// Scoreboard for the RMS meter: predicts each result item and compares it field by field.
module rms_meter_checker #(
  parameter int WINDOW = rms_pkg::WINDOW_DEF
) (
  input  logic clk,
  input  logic rst,
  rms_in_if    samples,
  rms_out_if   results,
  output int   failures,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import rms_pkg::*;

  typedef struct {
    logic [RMS_W-1:0] rms;
    logic             window_done;
  } reading_t;

  int unsigned      window_fill;
  logic [63:0]      square_sum;
  logic [RMS_W-1:0] last_rms;
  reading_t         pending_readings[$];

  // Builds the root one bit at a time, from the top bit down.
  function automatic logic [RMS_W:0] floor_sqrt(logic [63:0] v);
    logic [RMS_W:0] root;
    logic [RMS_W:0] trial;
    root = '0;
    for (int b = RMS_W; b >= 0; b--) begin
      trial = root | ((RMS_W+1)'(1) << b);
      if (64'(trial) * 64'(trial) <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Accumulates one sample and returns the reading the meter must report for it.
  function automatic reading_t meter_step(logic signed [SAMPLE_W-1:0] s);
    logic [MAG_W-1:0] mag;
    reading_t         r;
    mag = s[SAMPLE_W-1] ? (MAG_W'(0) - MAG_W'(s)) : MAG_W'(s);
    square_sum = square_sum + 64'(mag) * 64'(mag);
    r.window_done = 1'b0;
    if (window_fill >= WINDOW - 1) begin
      last_rms = RMS_W'(floor_sqrt(square_sum / 64'(WINDOW)));
      square_sum = '0;
      window_fill = 0;
      r.window_done = 1'b1;
    end else begin
      window_fill++;
    end
    r.rms = last_rms;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reading_t want;
    if (rst) begin
      window_fill = 0;
      square_sum = '0;
      last_rms = '0;
      pending_readings.delete();
    end else begin
      // Compare before predicting, so a spurious result is never matched to
      // the item accepted at the same edge.
      if (results.valid && results.ready) begin
        if (pending_readings.size() == 0) begin
          $error("unexpected result: rms %0d window_done %0b", results.rms,
                 results.window_done);
          failures++;
        end else begin
          want = pending_readings.pop_front();
          if (results.rms !== want.rms) begin
            $error("rms: expected %0d, got %0d", want.rms, results.rms);
            failures++;
          end
          if (results.window_done !== want.window_done) begin
            $error("window_done: expected %0b, got %0b", want.window_done,
                   results.window_done);
            failures++;
          end
        end
      end
      if (samples.valid && samples.ready) begin
        pending_readings.push_back(meter_step(samples.sample));
      end
    end
    outstanding = pending_readings.size();
  end

endmodule

// ===== test/tb_block_rms_meter.sv =====
// Testbench top for the RMS meter: drives samples and result stalls, and gives the verdict.
module tb_block_rms_meter;
  timeunit 1ns;
  timeprecision 1ps;
  import rms_pkg::*;

  localparam int WINDOW     = WINDOW_DEF;
  localparam int ITEM_TOTAL = 650;
  // The last items run with both sides streaming, with no idle cycles inserted by the bench.
  localparam int QUIET_TAIL = 80;
  localparam int DRAIN_MAX  = 20000;
  // A closing item costs up to one divide step per sum bit plus the root steps.
  localparam int SETTLE     = 120;

  localparam logic signed [SAMPLE_W-1:0] MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] MOST_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};

  // How the samples of one window are drawn in the random part.
  typedef enum int {
    STY_FULL,
    STY_MOST_NEG,
    STY_MOST_POS,
    STY_SMALL,
    STY_EXTREMES,
    STY_FLAT
  } window_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rms_in_if  samples ();
  rms_out_if results ();

  int            failures;
  int            outstanding;
  int            sent = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  bit            quiet = 1'b0;
  window_style_t style = STY_FULL;
  logic signed [SAMPLE_W-1:0] flat_level = '0;

  block_rms_meter #(.WINDOW(WINDOW)) uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results)
  );

  rms_meter_checker #(.WINDOW(WINDOW)) scoreboard (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .results     (results),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  // Offers one sample, possibly after a burst of idle cycles, and holds it
  // until the meter takes it. Inputs change only at the falling edge, and
  // valid is written once per edge so it never drops between back-to-back
  // items.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
    if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
      samples.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    samples.valid  <= 1'b1;
    samples.sample <= s;
    do @(posedge clk); while (!samples.ready);
    @(negedge clk);
    sent++;
  endtask

  // Stops offering items until the scoreboard holds no expected reading.
  task automatic wait_for_drain();
    samples.valid <= 1'b0;
    for (int i = 0; i < DRAIN_MAX && outstanding != 0; i++) begin
      @(negedge clk);
    end
  endtask

  // Draws the next sample of the current window according to its style.
  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    logic signed [SAMPLE_W-1:0] s;
    case (style)
      STY_MOST_NEG: s = MOST_NEG;
      STY_MOST_POS: s = MOST_POS;
      STY_SMALL:    s = SAMPLE_W'($urandom_range(0, 511)) - SAMPLE_W'(256);
      STY_EXTREMES: begin
        case ($urandom_range(0, 3))
          0:       s = MOST_NEG;
          1:       s = MOST_POS;
          2:       s = '0;
          default: s = -MOST_POS;
        endcase
      end
      STY_FLAT:     s = flat_level;
      default:      s = SAMPLE_W'($urandom);
    endcase
    return s;
  endfunction

  // Result side: ready drops in bursts of random length. The stall rate is
  // redrawn from time to time, so there are stretches with no stalls too.
  initial begin : receiver
    int stall;
    int cycle;
    stall = 0;
    cycle = 0;
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      cycle++;
      if (cycle % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       recv_idle_pct = 0;
          1:       recv_idle_pct = 5;
          default: recv_idle_pct = 25;
        endcase
      end
      if (!quiet && stall > 0) begin
        results.ready <= 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
        results.ready <= 1'b0;
        stall = $urandom_range(1, 14) - 1;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic signed [SAMPLE_W-1:0] directed[$];
    bit first_window;
    samples.valid  = 1'b0;
    samples.sample = '0;
    first_window = 1'b1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: the extremes of the sample, alternating bit patterns and
    // a few magnitudes around perfect squares. Nothing closes a window yet, so
    // rms must read zero throughout.
    directed = '{'0, 16'sd1, -16'sd1, MOST_POS, MOST_NEG, 16'sh5555, 16'shAAAA,
                 16'sd2, -16'sd2, 16'sd181, -16'sd181, 16'sd255, -16'sd256,
                 16'sd16384, -16'sd16384, 16'sd12345};
    foreach (directed[i]) begin
      send_sample(directed[i]);
    end

    // Let every reading come back before the random part starts.
    wait_for_drain();

    // Random part. Every window gets a style of its own; the first window that
    // starts in it is all most-negative samples, whose RMS is 32768, the largest
    // RMS the meter can report.
    while (sent < ITEM_TOTAL) begin
      if (sent % WINDOW == 0) begin
        if (first_window) begin
          style = STY_MOST_NEG;
          first_window = 1'b0;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: style = STY_FULL;
            4:          style = STY_MOST_NEG;
            5:          style = STY_MOST_POS;
            6:          style = STY_SMALL;
            7:          style = STY_EXTREMES;
            default:    style = STY_FLAT;
          endcase
        end
        flat_level = SAMPLE_W'($urandom);
        case ($urandom_range(0, 2))
          0:       send_idle_pct = 0;
          1:       send_idle_pct = 10;
          default: send_idle_pct = 35;
        endcase
      end
      if (sent == ITEM_TOTAL / 2) begin
        wait_for_drain();
      end
      if (sent == ITEM_TOTAL - QUIET_TAIL) begin
        quiet = 1'b1;
      end
      send_sample(draw_sample());
    end

    // All items are in: wait for the last readings, then watch a while longer
    // for anything spurious.
    wait_for_drain();
    repeat (SETTLE) @(negedge clk);
    if (outstanding != 0) begin
      $error("%0d expected results never arrived", outstanding);
    end
    if (failures == 0 && outstanding == 0) begin
      $display("tb_block_rms_meter OK");
    end else begin
      $display("tb_block_rms_meter NOT OK");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("tb_block_rms_meter NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rms_pkg.sv
rtl/rms_in_if.sv
rtl/rms_out_if.sv
rtl/rms_csub.sv
rtl/rms_core.sv
rtl/block_rms_meter.sv
test/rms_meter_checker.sv
test/tb_block_rms_meter.sv
